// File: design/text_console_put_char_macros.svh
// ----------------------------------------------------------------------------
// text console assertion macros
// clocked property shorthands shared by the console rtl
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_PUT_CHAR_MACROS_SVH
`define TEXT_CONSOLE_PUT_CHAR_MACROS_SVH

// same-cycle implication, held off during reset
`define TCON_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console: same-cycle check failed");

// next-cycle implication, held off during reset
`define TCON_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console: next-cycle check failed");

`endif

// File: design/tcon_pkg.sv
// ----------------------------------------------------------------------------
// tcon_pkg
// fixed codes and field widths of the text console
// ----------------------------------------------------------------------------
package tcon_pkg;

    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 5;
    localparam int CHAR_W    = 8;

    typedef logic [CHAR_W-1:0] t_char;

    localparam t_char CH_NEWLINE   = 8'h0A;
    localparam t_char CH_CLEAR     = 8'h03;
    localparam t_char CH_BACKSPACE = 8'h08;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

// File: design/text_console_put_char.sv
// ----------------------------------------------------------------------------
// text_console_put_char
// character-cell console: cursor handling, clear and scrolling over one
// screen memory, plus single-cell reads
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  command   in         start, busy (beat when    i_operation, i_char_code,
//                       start && !busy)           i_read_row, i_read_column
//  result    out        o_valid, one-cycle beat   o_cursor_column, o_cursor_row,
//                                                 o_cell_value
//
//  an ordinary put runs these steps from its accept to the next possible accept:
//  offset multiply, ring-base add, then the memory write and cursor update
//  a read adds a step in which the registered memory read data comes back
//  a scroll adds a pass that blanks the row that becomes the bottom row;
//  scrolling itself only moves the ring base, no rows are copied
//  clear (0x03) and reset both run a zeroing pass over the whole
//  memory, one cell a cycle, with busy high throughout
//  results are driven for one cycle and cannot be held off by the receiver
//
module text_console_put_char
    import tcon_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_operation,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [4:0]           i_read_row,
    input  logic [6:0]           i_read_column,
    output logic                 o_valid,
    output logic [OUT_COL_W-1:0] o_cursor_column,
    output logic [OUT_ROW_W-1:0] o_cursor_row,
    output logic [CHAR_W-1:0]    o_cell_value
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = AW + 1;

    // sequencer codes
    localparam logic [2:0] S_INIT  = 3'd0;   // zeroing pass over the whole memory
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_OFF   = 3'd2;   // row * COLUMNS + column
    localparam logic [2:0] S_PHYS  = 3'd3;   // add ring base, fold into range
    localparam logic [2:0] S_ACC   = 3'd4;   // write / cursor update / read issue
    localparam logic [2:0] S_RDATA = 3'd5;   // read data back from memory
    localparam logic [2:0] S_BLANK = 3'd6;   // zero the recycled bottom row

    // control state
    logic [2:0]           r_state,    n_state;
    logic [CW-1:0]        r_col,      n_col;
    logic [RW-1:0]        r_row,      n_row;
    logic [AW-1:0]        r_top_base, n_top_base;   // memory address of screen row 0
    logic [AW-1:0]        r_waddr,    n_waddr;      // sweep write pointer
    logic [CW-1:0]        r_bcnt,     n_bcnt;       // blanking column count
    logic                 r_valid,    n_valid;

    // payload
    logic                 r_op,       n_op;
    t_char                r_ch,       n_ch;
    logic [4:0]           r_rrow,     n_rrow;
    logic [6:0]           r_rcol,     n_rcol;
    logic                 r_in_range, n_in_range;
    logic [AW-1:0]        r_off,      n_off;
    logic [AW-1:0]        r_addr,     n_addr;
    logic [OUT_COL_W-1:0] r_out_col,  n_out_col;
    logic [OUT_ROW_W-1:0] r_out_row,  n_out_row;
    t_char                r_out_cell, n_out_cell;

    // screen memory, one synchronous write and one registered read port
    t_char                r_screen [CELLS];
    t_char                r_rd_data;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    t_char                mem_wd;

    // decode helpers
    logic                 is_nl, is_clr, is_bs, is_chr;
    logic                 col_last, row_last, col_zero, adv;
    logic [RW-1:0]        sel_row;
    logic [CW-1:0]        sel_col;
    logic [SW-1:0]        sum;

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_cursor_column = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_cell_value    = r_out_cell;

    assign is_nl    = (r_ch == CH_NEWLINE);
    assign is_clr   = (r_ch == CH_CLEAR);
    assign is_bs    = (r_ch == CH_BACKSPACE);
    assign is_chr   = !is_nl && !is_clr && !is_bs;
    assign col_last = (r_col == CW'(COLUMNS - 1));
    assign row_last = (r_row == RW'(ROWS - 1));
    assign col_zero = (r_col == '0);
    assign adv      = is_nl || (is_chr && col_last);

    // cell that this item touches: the read target, the cell left of the
    // cursor for backspace, else the cursor cell
    always_comb begin
        if (r_op == OP_READ) begin
            sel_row = RW'(r_rrow);
            sel_col = CW'(r_rcol);
        end else if (is_bs) begin
            sel_row = r_row;
            sel_col = r_col - CW'(1);
        end else begin
            sel_row = r_row;
            sel_col = r_col;
        end
    end

    assign sum = SW'(r_off) + SW'(r_top_base);

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_top_base = r_top_base;
        n_waddr    = r_waddr;
        n_bcnt     = r_bcnt;
        n_valid    = 1'b0;
        n_op       = r_op;
        n_ch       = r_ch;
        n_rrow     = r_rrow;
        n_rcol     = r_rcol;
        n_in_range = r_in_range;
        n_off      = r_off;
        n_addr     = r_addr;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_cell = r_out_cell;
        mem_we     = 1'b0;
        mem_wa     = r_addr;
        mem_wd     = '0;

        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wa = r_waddr;
                if (r_waddr == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_waddr = r_waddr + AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_op       = i_operation;
                    n_ch       = i_char_code;
                    n_rrow     = i_read_row;
                    n_rcol     = i_read_column;
                    n_in_range = (32'(i_read_row) < ROWS) && (32'(i_read_column) < COLUMNS);
                    n_state    = S_OFF;
                end
            end
            S_OFF: begin
                n_off   = AW'(sel_row * COLUMNS) + AW'(sel_col);
                n_state = S_PHYS;
            end
            S_PHYS: begin
                // both terms are below CELLS, so one subtract folds the sum
                if (sum >= SW'(CELLS)) begin
                    n_addr = AW'(sum - SW'(CELLS));
                end else begin
                    n_addr = AW'(sum);
                end
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_op == OP_READ) begin
                    n_state = S_RDATA;
                end else begin
                    n_state = S_IDLE;
                    if (is_clr) begin
                        n_col      = '0;
                        n_row      = '0;
                        n_top_base = '0;
                        n_waddr    = '0;
                        n_state    = S_INIT;
                    end else if (is_bs) begin
                        if (!col_zero) begin
                            mem_we = 1'b1;
                            n_col  = r_col - CW'(1);
                        end
                    end else if (is_chr) begin
                        mem_we = 1'b1;
                        mem_wd = r_ch;
                        if (!col_last) begin
                            n_col = r_col + CW'(1);
                        end
                    end
                    if (adv) begin
                        n_col = '0;
                        if (row_last) begin
                            // scroll: the old top row becomes the new bottom row
                            n_waddr = r_top_base;
                            n_bcnt  = '0;
                            n_state = S_BLANK;
                            if (r_top_base == AW'(CELLS - COLUMNS)) begin
                                n_top_base = '0;
                            end else begin
                                n_top_base = r_top_base + AW'(COLUMNS);
                            end
                        end else begin
                            n_row = r_row + RW'(1);
                        end
                    end
                    n_valid    = 1'b1;
                    n_out_col  = OUT_COL_W'(n_col);
                    n_out_row  = OUT_ROW_W'(n_row);
                    n_out_cell = '0;
                end
            end
            S_RDATA: begin
                n_valid    = 1'b1;
                n_out_col  = OUT_COL_W'(r_col);
                n_out_row  = OUT_ROW_W'(r_row);
                n_out_cell = r_in_range ? r_rd_data : '0;
                n_state    = S_IDLE;
            end
            S_BLANK: begin
                mem_we  = 1'b1;
                mem_wa  = r_waddr;
                n_waddr = r_waddr + AW'(1);
                n_bcnt  = r_bcnt + CW'(1);
                if (r_bcnt == CW'(COLUMNS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_waddr = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_col      <= '0;
            r_row      <= '0;
            r_top_base <= '0;
            r_waddr    <= '0;
            r_bcnt     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_top_base <= n_top_base;
            r_waddr    <= n_waddr;
            r_bcnt     <= n_bcnt;
            r_valid    <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_ch       <= n_ch;
        r_rrow     <= n_rrow;
        r_rcol     <= n_rcol;
        r_in_range <= n_in_range;
        r_off      <= n_off;
        r_addr     <= n_addr;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
        r_out_cell <= n_out_cell;
    end

    // screen memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_screen[r_addr];
    end

`include "text_console_put_char_macros.svh"

    `TCON_ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, start && !busy, busy)
    `TCON_ASSERT_NOW(a_cursor_in_range, i_clk, i_rst_n, 1'b1, (32'(r_col) < COLUMNS) && (32'(r_row) < ROWS))
    `TCON_ASSERT_NOW(a_put_reads_zero, i_clk, i_rst_n, r_valid && (r_op == OP_PUT), r_out_cell == '0)
    `TCON_ASSERT_NOW(a_write_in_range, i_clk, i_rst_n, mem_we, 32'(mem_wa) < CELLS)

endmodule

// File: tb/sv/tb_text_console_put_char.sv
// ----------------------------------------------------------------------------
// tb_text_console_put_char
// self-checking bench for the text console: a queue of put and read commands
// is driven through the start/busy handshake, every accepted beat is run
// through a behavioural screen model, and each result strobe is compared with
// the oldest predicted cursor position and cell value
// ----------------------------------------------------------------------------
module tb_text_console_put_char;
    import tcon_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int ITEM_TARGET = 1650;
    // no sender gaps once the queue has drained this far
    localparam int QUIET_TAIL  = 150;
    // a clear or the reset zeroing pass is the longest silent stretch
    localparam int STALL_LIMIT = 4 * (ROWS * COLUMNS + COLUMNS + 64);
    localparam int SETTLE      = 40;

    // one command as queued for the driver; pause marks a drain point
    typedef struct packed {
        logic                  pause;
        logic                  op;
        t_char                 ch;
        logic [4:0]            row;
        logic [6:0]            col;
    } t_console_cmd;

    // what the console reports after one command
    typedef struct packed {
        logic [OUT_COL_W-1:0]  col;
        logic [OUT_ROW_W-1:0]  row;
        t_char                 cell_val;
    } t_console_view;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_operation = OP_PUT;
    logic [CHAR_W-1:0]     i_char_code = '0;
    logic [4:0]            i_read_row = '0;
    logic [6:0]            i_read_column = '0;
    logic                  o_valid;
    logic [OUT_COL_W-1:0]  o_cursor_column;
    logic [OUT_ROW_W-1:0]  o_cursor_row;
    logic [CHAR_W-1:0]     o_cell_value;

    t_console_cmd  pending_cmds[$];
    t_console_view awaited_views[$];

    // shadow screen and cursor
    t_char         shadow_screen[ROWS][COLUMNS];
    int unsigned   shadow_col;
    int unsigned   shadow_row;

    int            item_count;
    int            error_count;
    int            gap_left;
    int            calm_left;
    int            stall_cycles;

    text_console_put_char #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_char_code     (i_char_code),
        .i_read_row      (i_read_row),
        .i_read_column   (i_read_column),
        .o_valid         (o_valid),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_cell_value    (o_cell_value)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // screen model: applies one accepted command, returns what the
    // console should report
    // ------------------------------------------------------------------
    function automatic t_console_view console_apply(t_console_cmd c);
        t_console_view v;
        t_char         value;
        value = '0;
        if (c.op == OP_READ) begin
            // out-of-screen reads give zero
            if (c.row < ROWS && c.col < COLUMNS)
                value = shadow_screen[c.row][c.col];
        end else begin
            case (c.ch)
                CH_NEWLINE: begin
                    shadow_col = 0;
                    shadow_row++;
                end
                CH_CLEAR: begin
                    shadow_col = 0;
                    shadow_row = 0;
                    foreach (shadow_screen[r, k]) shadow_screen[r][k] = '0;
                end
                CH_BACKSPACE: begin
                    // nothing happens at the left margin
                    if (shadow_col > 0) begin
                        shadow_col--;
                        shadow_screen[shadow_row][shadow_col] = '0;
                    end
                end
                default: begin
                    shadow_screen[shadow_row][shadow_col] = c.ch;
                    shadow_col++;
                end
            endcase
            // wrap at the right margin
            if (shadow_col >= COLUMNS) begin
                shadow_col = 0;
                shadow_row++;
            end
            // past the bottom: scroll up, blank the last row, park the cursor
            if (shadow_row >= ROWS) begin
                for (int r = 0; r < ROWS - 1; r++)
                    shadow_screen[r] = shadow_screen[r + 1];
                for (int k = 0; k < COLUMNS; k++)
                    shadow_screen[ROWS - 1][k] = '0;
                shadow_col = 0;
                shadow_row = ROWS - 1;
            end
        end
        v.col      = shadow_col[OUT_COL_W-1:0];
        v.row      = shadow_row[OUT_ROW_W-1:0];
        v.cell_val = value;
        return v;
    endfunction

    // put command; the read fields carry junk since they are ignored
    task automatic push_put(t_char ch);
        t_console_cmd c;
        c.pause = 1'b0;
        c.op    = OP_PUT;
        c.ch    = ch;
        c.row   = 5'($urandom_range(0, 31));
        c.col   = 7'($urandom_range(0, 127));
        pending_cmds.push_back(c);
        item_count++;
    endtask

    // read command; char_code carries junk
    task automatic push_read(int unsigned row, int unsigned col);
        t_console_cmd c;
        c.pause = 1'b0;
        c.op    = OP_READ;
        c.ch    = 8'($urandom_range(0, 255));
        c.row   = row[4:0];
        c.col   = col[6:0];
        pending_cmds.push_back(c);
        item_count++;
    endtask

    // sender holds off here until every outstanding result has arrived
    task automatic push_pause();
        t_console_cmd c;
        c       = '0;
        c.pause = 1'b1;
        pending_cmds.push_back(c);
    endtask

    // ------------------------------------------------------------------
    // driver: presents the front of the queue, predicts at each accepted
    // beat, inserts random idle bursts while plenty of work remains
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        logic accepted;
        if (!i_rst_n) begin
            start     <= 1'b0;
            gap_left  = 0;
            calm_left = 0;
        end else begin
            accepted = start && !busy;
            if (accepted) begin
                awaited_views.push_back(console_apply(pending_cmds[0]));
                void'(pending_cmds.pop_front());
                if (calm_left > 0) begin
                    calm_left--;
                end else if (pending_cmds.size() > QUIET_TAIL) begin
                    if ($urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 18);
                    else if ($urandom_range(0, 39) == 0)
                        calm_left = $urandom_range(20, 60);
                end
            end

            if (start && !accepted) begin
                // command still waiting on busy, hold everything
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() != 0 && pending_cmds[0].pause) begin
                if (awaited_views.size() == 0)
                    void'(pending_cmds.pop_front());
                start <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                start         <= 1'b1;
                i_operation   <= pending_cmds[0].op;
                i_char_code   <= pending_cmds[0].ch;
                i_read_row    <= pending_cmds[0].row;
                i_read_column <= pending_cmds[0].col;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every result strobe is one beat, matched against the
    // oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_console_view want;
        if (i_rst_n && o_valid) begin
            if (awaited_views.size() == 0) begin
                $error("result beat with nothing awaited: col %0d row %0d cell %0h",
                       o_cursor_column, o_cursor_row, o_cell_value);
                error_count++;
            end else begin
                want = awaited_views.pop_front();
                if (o_cursor_column !== want.col) begin
                    $error("cursor_column: expected %0d, got %0d", want.col, o_cursor_column);
                    error_count++;
                end
                if (o_cursor_row !== want.row) begin
                    $error("cursor_row: expected %0d, got %0d", want.row, o_cursor_row);
                    error_count++;
                end
                if (o_cell_value !== want.cell_val) begin
                    $error("cell_value: expected %0h, got %0h", want.cell_val, o_cell_value);
                    error_count++;
                end
            end
        end
    end

    // watchdog: counts cycles in which no beat moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int pick;
        int len;
        item_count   = 0;
        error_count  = 0;
        stall_cycles = 0;
        shadow_col   = 0;
        shadow_row   = 0;
        foreach (shadow_screen[r, k]) shadow_screen[r][k] = '0;

        // directed: corners of the screen, specials, out-of-screen reads
        push_read(0, 0);
        push_read(ROWS - 1, COLUMNS - 1);
        push_put(CH_BACKSPACE);             // at the left margin, no effect
        push_put(8'h00);
        push_put(8'hFF);
        push_put(8'h41);
        push_read(0, 0);
        push_read(0, 1);
        push_read(0, 2);
        push_put(CH_BACKSPACE);             // blanks the 0x41 cell
        push_read(0, 2);
        push_put(CH_NEWLINE);
        push_put(8'h7E);
        push_read(31, 127);                 // every read-field bit high
        push_read(ROWS, 0);                 // first row below the screen
        push_read(0, COLUMNS);              // first column beyond the screen
        push_read(1, 0);
        push_pause();
        push_put(CH_CLEAR);
        push_read(1, 0);
        push_read(0, 1);
        push_put(CH_NEWLINE);
        push_put(8'h20);

        // random: runs of text mostly ending in newlines, backspace bursts, reads,
        // newline bursts that push the screen into scrolling, some noise
        while (item_count < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100)
                                                  : $urandom_range(1, 20);
                repeat (len)
                    push_put(($urandom_range(0, 3) != 0) ? 8'($urandom_range(32, 126))
                                                         : 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) < 6)
                    push_put(CH_NEWLINE);
            end else if (pick < 62) begin
                repeat ($urandom_range(1, 6)) push_put(CH_BACKSPACE);
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 4) == 0)
                        push_read($urandom_range(0, 31), $urandom_range(0, 127));
                    else
                        push_read(($urandom_range(0, 1) != 0) ? ROWS - 1
                                                              : $urandom_range(0, ROWS - 1),
                                  $urandom_range(0, COLUMNS - 1));
                end
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 8)) push_put(CH_NEWLINE);
            end else if (pick < 97) begin
                repeat ($urandom_range(1, 6)) push_put(8'($urandom_range(0, 255)));
            end else if (pick < 99) begin
                push_put(CH_CLEAR);
            end else begin
                push_pause();
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait until every command is taken and every result has come back
        while (pending_cmds.size() != 0 || awaited_views.size() != 0 || start)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (error_count == 0 && awaited_views.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
